// ===== rtl/core/gwma_pkg.sv =====
package gwma_pkg;

  localparam int MAX_WINDOW   = 100;
  localparam int WINDOW_RESET = 20;

  localparam int SAMPLE_W = 15;
  localparam int AVG_W    = 16;
  localparam int WIN_W    = 7;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    int v;
    v = int'(w);
    if (v > MAX_WINDOW) begin
      v = MAX_WINDOW;
    end
    return CNT_W'(v);
  endfunction

endpackage

// ===== rtl/core/gwma_ram.sv =====
module gwma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/growing_window_moving_average.sv =====
// Growing-window moving average of sensor samples.
// Input channel: in_valid / in_stall with payload sample (15 bits unsigned).
// Output channel: out_valid / out_stall with payload average (16 bits signed).
// Configuration: cfg_we / cfg_wdata writes window_len; write only while idle.
// Each beat pushes the sample into a circular history of MAX_WINDOW entries,
// grows the fill count up to the window and returns the truncated mean of the
// newest fill-count samples. A window of zero returns -1 and pushes nothing.
// One beat is worked at a time: in_stall is high from acceptance until the
// result has been handed to the output register.
// Each beat is worked in order: one history read per sample through
// the single RAM read port, then a 22-step restoring divider, one
// quotient bit per cycle, then the load of the output register. A zero
// window goes straight from acceptance to the output register load.
// The output register holds a result while out_stall is high; the next beat
// is still accepted and worked, and waits at the end for the register to free.
// Reset (rst, synchronous): window_len returns to 20, fill count to zero,
// output empty. The history needs no clearing: only entries written since
// reset are ever summed.
module growing_window_moving_average (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gwma_pkg::SAMPLE_W-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gwma_pkg::AVG_W-1:0]   average,
  input  logic                                cfg_we,
  input  logic [gwma_pkg::WIN_W-1:0]          cfg_wdata
);

  import gwma_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  state_t             state;
  logic [WIN_W-1:0]   window_len;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   issue_left;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               rd_pend;
  logic [SUM_W-1:0]   acc;
  logic [CNT_W-1:0]   rem;
  logic [STEP_W-1:0]  step;
  logic               err;

  logic               accept;
  logic [CNT_W-1:0]   win_now;
  logic [CNT_W-1:0]   win_cfg;
  logic [CNT_W-1:0]   fill_clamped;
  logic [CNT_W-1:0]   fill_next;
  logic [SAMPLE_W-1:0] rd_data;
  logic [CNT_W:0]     trial;
  logic               trial_ge;
  logic [CNT_W:0]     trial_diff;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign win_now  = eff_window(window_len);
  assign win_cfg  = eff_window(cfg_wdata);

  always_comb begin
    fill_clamped = (fill_count > win_now) ? win_now : fill_count;
    fill_next    = (fill_clamped < win_now) ? fill_clamped + 1'b1 : fill_clamped;
  end

  assign trial      = {rem, acc[SUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, fill_count});
  assign trial_diff = trial - {1'b0, fill_count};

  gwma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (accept && (win_now != '0)),
    .waddr (wr_ptr),
    .wdata (sample),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window_len <= WIN_W'(WINDOW_RESET);
      fill_count <= '0;
      wr_ptr     <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        window_len <= cfg_wdata;
        if (fill_count > win_cfg) begin
          fill_count <= win_cfg;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (win_now == '0) begin
              err   <= 1'b1;
              state <= S_DONE;
            end else begin
              err        <= 1'b0;
              fill_count <= fill_next;
              issue_left <= fill_next;
              rd_ptr     <= wr_ptr;
              wr_ptr     <= (wr_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
              rd_pend    <= 1'b0;
              acc        <= '0;
              state      <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (rd_pend) begin
            acc <= acc + SUM_W'(rd_data);
          end
          if (issue_left != '0) begin
            issue_left <= issue_left - 1'b1;
            rd_ptr     <= (rd_ptr == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr - 1'b1;
            rd_pend    <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            rem     <= '0;
            step    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
          acc  <= {acc[SUM_W-2:0], trial_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            average   <= err ? '1 : acc[AVG_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block took a beat and did not go busy");

  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (fill_count <= win_now))
    else $error("fill count exceeds the window");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (fill_count != '0))
    else $error("divide by zero fill count");

  a_wr_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= PTR_W'(MAX_WINDOW - 1))
    else $error("history write pointer out of range");

endmodule
